@@ design/neutrino_pz_from_w_mass_top_defines.svh @@
// Assertion macros for the neutrino pz block.
`ifndef NEUTRINO_PZ_FROM_W_MASS_TOP_DEFINES_SVH
`define NEUTRINO_PZ_FROM_W_MASS_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define NPZ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NPZ_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPZ_ASSERT(label, prop, msg)
`define NPZ_ASSERT_RST(label, prop, msg)
`endif

`endif

@@ design/npz_pkg.sv @@
package npz_pkg;

  localparam int F_W     = 20;   // momentum fields
  localparam int E_W     = 19;   // lepton energy
  localparam int W_W     = 12;   // w mass register
  localparam int M_W     = 42;   // w^2 + 2*(met . lep)
  localparam int D_W     = 40;   // E^2 - pz^2
  localparam int S_W     = 40;   // met^2
  localparam int DEN_W   = 40;   // 2*|D|
  localparam int Q_W     = 84;   // discriminant
  localparam int R_W     = Q_W / 2;
  localparam int NUM_W   = 64;   // quotient numerator
  localparam int PZ_W    = 20;
  localparam int X_W     = 40;   // met^2 + pz^2
  localparam int XR_W    = X_W / 2;
  localparam int DIV_LAT = PZ_W + 4;

  localparam logic [W_W-1:0]  W_MASS_RESET = 12'd1286;
  localparam logic [PZ_W-1:0] SAT_POS      = 20'h7FFFF;
  localparam logic [PZ_W-1:0] SAT_NEG      = 20'h80000;
  localparam logic [XR_W-1:0] EN_MAX       = 20'hFFFFF;

endpackage

@@ design/neutrino_pz_from_w_mass_top.sv @@
// channel   direction  handshake            payload
// item      in         start && !busy       lep_px lep_py lep_pz lep_energy met_px met_py
// result    out        done (one cycle)     nu_pz_plus/minus nu_energy_plus/minus flags
// config    in         w_mass_wr            w_mass_data
//
// Fully pipelined: one item per cycle, busy is always low.
// Its depth is set mostly by the 42-stage discriminant root, the
// 24-stage rounding divider and the 20-stage energy root.
// Synchronous reset empties the pipeline and loads w_mass = 1286.
// Results are shown for one cycle on done; the receiver cannot stall.
`include "neutrino_pz_from_w_mass_top_defines.svh"

module neutrino_pz_from_w_mass_top
  import npz_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [F_W-1:0]  lep_px,
  input  logic signed [F_W-1:0]  lep_py,
  input  logic signed [F_W-1:0]  lep_pz,
  input  logic [E_W-1:0]         lep_energy,
  input  logic signed [F_W-1:0]  met_px,
  input  logic signed [F_W-1:0]  met_py,
  input  logic                   w_mass_wr,
  input  logic [W_W-1:0]         w_mass_data,
  output logic                   done,
  output logic signed [PZ_W-1:0] nu_pz_plus,
  output logic signed [PZ_W-1:0] nu_pz_minus,
  output logic [XR_W-1:0]        nu_energy_plus,
  output logic [XR_W-1:0]        nu_energy_minus,
  output logic                   complex_roots,
  output logic                   bad_input
);

  localparam int LATENCY = 6 + R_W + 2 + DIV_LAT + 3 + XR_W + 1;
  localparam int SQ_SIDE_W = NUM_W + DEN_W + S_W + E_W + 2;

  logic [W_W-1:0] w_mass;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_mass <= W_MASS_RESET;
    end else if (w_mass_wr) begin
      w_mass <= w_mass_data;
    end
  end

  assign busy = 1'b0;

  // stage 1: products
  logic                    s1_vld;
  logic signed [2*F_W-1:0] s1_pxx, s1_pyy, s1_zz, s1_mxx, s1_myy;
  logic [2*E_W-1:0]        s1_ee;
  logic [2*W_W-1:0]        s1_ww;
  logic signed [F_W-1:0]   s1_lz;
  logic [E_W-1:0]          s1_e;

  always_ff @(posedge clk) begin
    s1_pxx <= met_px * lep_px;
    s1_pyy <= met_py * lep_py;
    s1_zz  <= lep_pz * lep_pz;
    s1_mxx <= met_px * met_px;
    s1_myy <= met_py * met_py;
    s1_ee  <= lep_energy * lep_energy;
    s1_ww  <= w_mass * w_mass;
    s1_lz  <= lep_pz;
    s1_e   <= lep_energy;
  end

  // stage 2: M, D, S
  logic                  s2_vld;
  logic [M_W-1:0]        s2_m;
  logic [D_W-1:0]        s2_d;
  logic [S_W-1:0]        s2_s;
  logic signed [F_W-1:0] s2_lz;
  logic [E_W-1:0]        s2_e;
  logic [M_W-1:0]        dot_sum;

  assign dot_sum = {{2{s1_pxx[2*F_W-1]}}, s1_pxx} + {{2{s1_pyy[2*F_W-1]}}, s1_pyy};

  always_ff @(posedge clk) begin
    s2_m  <= {{(M_W-2*W_W){1'b0}}, s1_ww} + {dot_sum[M_W-2:0], 1'b0};
    s2_d  <= {2'b00, s1_ee} - s1_zz;
    s2_s  <= $unsigned(s1_mxx) + $unsigned(s1_myy);
    s2_lz <= s1_lz;
    s2_e  <= s1_e;
  end

  // stage 3: magnitudes and M*lz
  logic                      s3_vld;
  logic [M_W-1:0]            s3_am;
  logic [D_W-1:0]            s3_ad;
  logic signed [M_W+F_W-1:0] s3_base;
  logic                      s3_dneg, s3_bad;
  logic [DEN_W-1:0]          s3_den;
  logic [S_W-1:0]            s3_s;
  logic [E_W-1:0]            s3_e;
  logic [D_W-1:0]            d_abs;

  assign d_abs = s2_d[D_W-1] ? (~s2_d + 1'b1) : s2_d;

  always_ff @(posedge clk) begin
    s3_am   <= s2_m[M_W-1] ? (~s2_m + 1'b1) : s2_m;
    s3_ad   <= d_abs;
    s3_base <= $signed(s2_m) * s2_lz;
    s3_dneg <= s2_d[D_W-1];
    s3_bad  <= (s2_d == '0);
    s3_den  <= {d_abs[DEN_W-2:0], 1'b0};
    s3_s    <= s2_s;
    s3_e    <= s2_e;
  end

  // stage 4: partial products of M^2 and |D|*S, signed base
  localparam int MH = M_W / 2;
  localparam int DH = D_W / 2;
  logic                s4_vld;
  logic [2*MH-1:0]     s4_mhh, s4_mhl, s4_mll;
  logic [2*DH-1:0]     s4_dhh, s4_dhl, s4_dlh, s4_dll;
  logic [NUM_W-1:0]    s4_base;
  logic                s4_dneg, s4_bad;
  logic [DEN_W-1:0]    s4_den;
  logic [S_W-1:0]      s4_s;
  logic [E_W-1:0]      s4_e;
  logic [NUM_W-1:0]    base_ext;

  assign base_ext = {{(NUM_W-M_W-F_W){s3_base[M_W+F_W-1]}}, s3_base};

  always_ff @(posedge clk) begin
    s4_mhh  <= s3_am[M_W-1:MH] * s3_am[M_W-1:MH];
    s4_mhl  <= s3_am[M_W-1:MH] * s3_am[MH-1:0];
    s4_mll  <= s3_am[MH-1:0] * s3_am[MH-1:0];
    s4_dhh  <= s3_ad[D_W-1:DH] * s3_s[S_W-1:DH];
    s4_dhl  <= s3_ad[D_W-1:DH] * s3_s[DH-1:0];
    s4_dlh  <= s3_ad[DH-1:0] * s3_s[S_W-1:DH];
    s4_dll  <= s3_ad[DH-1:0] * s3_s[DH-1:0];
    s4_base <= s3_dneg ? (~base_ext + 1'b1) : base_ext;
    s4_dneg <= s3_dneg;
    s4_bad  <= s3_bad;
    s4_den  <= s3_den;
    s4_s    <= s3_s;
    s4_e    <= s3_e;
  end

  // stage 5: M^2 and 4*|D|*S
  logic             s5_vld;
  logic [Q_W-1:0]   s5_m2, s5_ds4;
  logic [NUM_W-1:0] s5_base;
  logic             s5_dneg, s5_bad;
  logic [DEN_W-1:0] s5_den;
  logic [S_W-1:0]   s5_s;
  logic [E_W-1:0]   s5_e;
  logic [Q_W-1:0]   ds_sum;

  assign ds_sum = Q_W'({s4_dhh, {(2*DH){1'b0}}}) + Q_W'({s4_dhl, {DH{1'b0}}})
                + Q_W'({s4_dlh, {DH{1'b0}}}) + Q_W'(s4_dll);

  always_ff @(posedge clk) begin
    s5_m2   <= Q_W'({s4_mhh, {(2*MH){1'b0}}}) + Q_W'({s4_mhl, {(MH+1){1'b0}}})
             + Q_W'(s4_mll);
    s5_ds4  <= {ds_sum[Q_W-3:0], 2'b00};
    s5_base <= s4_base;
    s5_dneg <= s4_dneg;
    s5_bad  <= s4_bad;
    s5_den  <= s4_den;
    s5_s    <= s4_s;
    s5_e    <= s4_e;
  end

  // stage 6: discriminant; a complex case feeds zero so the root is zero
  logic             s6_vld;
  logic [Q_W-1:0]   s6_q;
  logic             s6_cplx;
  logic [NUM_W-1:0] s6_base;
  logic             s6_bad;
  logic [DEN_W-1:0] s6_den;
  logic [S_W-1:0]   s6_s;
  logic [E_W-1:0]   s6_e;
  logic             m2_lt;

  assign m2_lt = (s5_m2 < s5_ds4);

  always_ff @(posedge clk) begin
    if (s5_dneg) begin
      s6_q <= s5_m2 + s5_ds4;
    end else if (m2_lt) begin
      s6_q <= '0;
    end else begin
      s6_q <= s5_m2 - s5_ds4;
    end
    s6_cplx <= !s5_dneg && m2_lt;
    s6_base <= s5_base;
    s6_bad  <= s5_bad;
    s6_den  <= s5_den;
    s6_s    <= s5_s;
    s6_e    <= s5_e;
  end

  logic                 sq_vld;
  logic [R_W-1:0]       sq_root;
  logic [SQ_SIDE_W-1:0] sq_side;
  logic [NUM_W-1:0]     sq_base;
  logic [DEN_W-1:0]     sq_den;
  logic [S_W-1:0]       sq_s;
  logic [E_W-1:0]       sq_e;
  logic                 sq_cplx, sq_bad;

  npz_isqrt_pipe #(
    .RAD_W  (Q_W),
    .SIDE_W (SQ_SIDE_W)
  ) u_disc_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s6_vld),
    .rad       (s6_q),
    .in_side   ({s6_base, s6_den, s6_s, s6_e, s6_cplx, s6_bad}),
    .out_valid (sq_vld),
    .root      (sq_root),
    .rem       (),
    .out_side  (sq_side)
  );

  assign {sq_base, sq_den, sq_s, sq_e, sq_cplx, sq_bad} = sq_side;

  // stage 7: E*r
  logic                 s7_vld;
  logic [E_W+R_W-1:0]   s7_t;
  logic [NUM_W-1:0]     s7_base;
  logic [DEN_W-1:0]     s7_den;
  logic [S_W-1:0]       s7_s;
  logic                 s7_cplx, s7_bad;

  always_ff @(posedge clk) begin
    s7_t    <= sq_e * sq_root;
    s7_base <= sq_base;
    s7_den  <= sq_den;
    s7_s    <= sq_s;
    s7_cplx <= sq_cplx;
    s7_bad  <= sq_bad;
  end

  // stage 8: numerators
  logic             s8_vld;
  logic [NUM_W-1:0] s8_n1, s8_n2;
  logic [DEN_W-1:0] s8_den;
  logic [S_W-1:0]   s8_s;
  logic             s8_cplx, s8_bad;

  always_ff @(posedge clk) begin
    s8_n1   <= s7_base + NUM_W'(s7_t);
    s8_n2   <= s7_base - NUM_W'(s7_t);
    s8_den  <= s7_den;
    s8_s    <= s7_s;
    s8_cplx <= s7_cplx;
    s8_bad  <= s7_bad;
  end

  logic                   dv_vld;
  logic signed [PZ_W-1:0] dv_q1, dv_q2;
  logic [S_W:0]           dv_side;
  logic                   dv_bad;

  npz_rdiv_pipe #(
    .SIDE_W (S_W + 1)
  ) u_div_plus (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s8_vld),
    .num       ($signed(s8_n1)),
    .den       (s8_den),
    .in_side   ({s8_s, s8_cplx}),
    .out_valid (dv_vld),
    .quot      (dv_q1),
    .out_side  (dv_side)
  );

  npz_rdiv_pipe #(
    .SIDE_W (1)
  ) u_div_minus (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s8_vld),
    .num       ($signed(s8_n2)),
    .den       (s8_den),
    .in_side   (s8_bad),
    .out_valid (),
    .quot      (dv_q2),
    .out_side  (dv_bad)
  );

  // stage 9: |pz|
  logic            s9_vld;
  logic [PZ_W-1:0] s9_pz1, s9_pz2, s9_a1, s9_a2;
  logic [S_W-1:0]  s9_s;
  logic            s9_cplx, s9_bad;

  always_ff @(posedge clk) begin
    s9_pz1  <= dv_q1;
    s9_pz2  <= dv_q2;
    s9_a1   <= dv_q1[PZ_W-1] ? (~dv_q1 + 1'b1) : dv_q1;
    s9_a2   <= dv_q2[PZ_W-1] ? (~dv_q2 + 1'b1) : dv_q2;
    s9_s    <= dv_side[S_W:1];
    s9_cplx <= dv_side[0];
    s9_bad  <= dv_bad;
  end

  // stage 10: pz^2
  logic              s10_vld;
  logic [2*PZ_W-1:0] s10_sq1, s10_sq2;
  logic [PZ_W-1:0]   s10_pz1, s10_pz2;
  logic [S_W-1:0]    s10_s;
  logic              s10_cplx, s10_bad;

  always_ff @(posedge clk) begin
    s10_sq1  <= s9_a1 * s9_a1;
    s10_sq2  <= s9_a2 * s9_a2;
    s10_pz1  <= s9_pz1;
    s10_pz2  <= s9_pz2;
    s10_s    <= s9_s;
    s10_cplx <= s9_cplx;
    s10_bad  <= s9_bad;
  end

  // stage 11: met^2 + pz^2
  logic            s11_vld;
  logic [X_W-1:0]  s11_x1, s11_x2;
  logic [PZ_W-1:0] s11_pz1, s11_pz2;
  logic            s11_cplx, s11_bad;

  always_ff @(posedge clk) begin
    s11_x1   <= s10_s + X_W'(s10_sq1);
    s11_x2   <= s10_s + X_W'(s10_sq2);
    s11_pz1  <= s10_pz1;
    s11_pz2  <= s10_pz2;
    s11_cplx <= s10_cplx;
    s11_bad  <= s10_bad;
  end

  logic            es_vld;
  logic [XR_W-1:0] es_r1, es_r2;
  logic [XR_W+2:0] es_rem1, es_rem2;
  logic [PZ_W:0]   es_side1, es_side2;

  npz_isqrt_pipe #(
    .RAD_W  (X_W),
    .SIDE_W (PZ_W + 1)
  ) u_en_plus (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s11_vld),
    .rad       (s11_x1),
    .in_side   ({s11_pz1, s11_cplx}),
    .out_valid (es_vld),
    .root      (es_r1),
    .rem       (es_rem1),
    .out_side  (es_side1)
  );

  npz_isqrt_pipe #(
    .RAD_W  (X_W),
    .SIDE_W (PZ_W + 1)
  ) u_en_minus (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s11_vld),
    .rad       (s11_x2),
    .in_side   ({s11_pz2, s11_bad}),
    .out_valid (),
    .root      (es_r2),
    .rem       (es_rem2),
    .out_side  (es_side2)
  );

  // round to nearest: bump when x - r^2 > r
  logic [XR_W:0] en1, en2;

  assign en1 = (es_rem1 > (XR_W+3)'(es_r1)) ? ({1'b0, es_r1} + 1'b1) : {1'b0, es_r1};
  assign en2 = (es_rem2 > (XR_W+3)'(es_r2)) ? ({1'b0, es_r2} + 1'b1) : {1'b0, es_r2};

  always_ff @(posedge clk) begin
    if (es_side2[0]) begin
      nu_pz_plus      <= '0;
      nu_pz_minus     <= '0;
      nu_energy_plus  <= '0;
      nu_energy_minus <= '0;
      complex_roots   <= 1'b0;
      bad_input       <= 1'b1;
    end else begin
      nu_pz_plus      <= $signed(es_side1[PZ_W:1]);
      nu_pz_minus     <= $signed(es_side2[PZ_W:1]);
      nu_energy_plus  <= en1[XR_W] ? EN_MAX : en1[XR_W-1:0];
      nu_energy_minus <= en2[XR_W] ? EN_MAX : en2[XR_W-1:0];
      complex_roots   <= es_side1[0];
      bad_input       <= 1'b0;
    end
  end

  // valid chain of the front and back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      s4_vld  <= 1'b0;
      s5_vld  <= 1'b0;
      s6_vld  <= 1'b0;
      s7_vld  <= 1'b0;
      s8_vld  <= 1'b0;
      s9_vld  <= 1'b0;
      s10_vld <= 1'b0;
      s11_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      s1_vld  <= start && !busy;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      s4_vld  <= s3_vld;
      s5_vld  <= s4_vld;
      s6_vld  <= s5_vld;
      s7_vld  <= sq_vld;
      s8_vld  <= s7_vld;
      s9_vld  <= dv_vld;
      s10_vld <= s9_vld;
      s11_vld <= s10_vld;
      done    <= es_vld;
    end
  end

  logic res_clear, res_pair_same, en_covers_pz;

  assign res_clear = nu_pz_plus == '0 && nu_pz_minus == '0 && nu_energy_plus == '0
                     && nu_energy_minus == '0 && !complex_roots;
  assign res_pair_same = nu_pz_plus == nu_pz_minus && nu_energy_plus == nu_energy_minus;
  assign en_covers_pz = nu_energy_plus >= $unsigned(nu_pz_plus);

  `NPZ_ASSERT(a_latency, done |-> $past(start, LATENCY), "result without matching transfer")
  `NPZ_ASSERT(a_bad_zero, done && bad_input |-> res_clear, "bad input result not cleared")
  `NPZ_ASSERT(a_cplx_same, done && complex_roots |-> res_pair_same, "complex case roots differ")
  `NPZ_ASSERT(a_energy_ge, done && !nu_pz_plus[PZ_W-1] |-> en_covers_pz, "energy below pz")
  `NPZ_ASSERT_RST(a_rst_quiet, rst |=> !done, "result strobe after reset")

endmodule

@@ design/npz_isqrt_pipe.sv @@
// Digit-by-digit integer square root, one result bit per stage.
// rem = rad - root^2.
module npz_isqrt_pipe #(
  parameter int RAD_W  = 84,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [RAD_W-1:0]      rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [RAD_W/2-1:0]    root,
  output logic [RAD_W/2+2:0]    rem,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  logic              stage_vld       [ROOT_W];
  logic              stage_vld_next  [ROOT_W];
  logic [RAD_W-1:0]  stage_rad       [ROOT_W];
  logic [RAD_W-1:0]  stage_rad_next  [ROOT_W];
  logic [REM_W-1:0]  stage_rem       [ROOT_W];
  logic [REM_W-1:0]  stage_rem_next  [ROOT_W];
  logic [ROOT_W-1:0] stage_root      [ROOT_W];
  logic [ROOT_W-1:0] stage_root_next [ROOT_W];
  logic [SIDE_W-1:0] stage_side      [ROOT_W];
  logic [SIDE_W-1:0] stage_side_next [ROOT_W];

  always_comb begin
    logic              v_in;
    logic [RAD_W-1:0]  r_in;
    logic [REM_W-1:0]  rm_in;
    logic [ROOT_W-1:0] rt_in;
    logic [SIDE_W-1:0] sd_in;
    logic [REM_W-1:0]  sh;
    logic [REM_W-1:0]  tr;
    logic              fits;
    for (int i = 0; i < ROOT_W; i++) begin
      if (i == 0) begin
        v_in  = in_valid;
        r_in  = rad;
        rm_in = '0;
        rt_in = '0;
        sd_in = in_side;
      end else begin
        v_in  = stage_vld[i-1];
        r_in  = stage_rad[i-1];
        rm_in = stage_rem[i-1];
        rt_in = stage_root[i-1];
        sd_in = stage_side[i-1];
      end
      // stored remainder never reaches its top two bits
      sh   = {rm_in[REM_W-3:0], r_in[RAD_W-1 -: 2]};
      tr   = {1'b0, rt_in, 2'b01};
      fits = (sh >= tr);
      stage_vld_next[i]  = v_in;
      stage_rad_next[i]  = r_in << 2;
      stage_rem_next[i]  = fits ? (sh - tr) : sh;
      stage_root_next[i] = {rt_in[ROOT_W-2:0], fits};
      stage_side_next[i] = sd_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ROOT_W; i++) begin
      stage_rad[i]  <= stage_rad_next[i];
      stage_rem[i]  <= stage_rem_next[i];
      stage_root[i] <= stage_root_next[i];
      stage_side[i] <= stage_side_next[i];
      if (rst) begin
        stage_vld[i] <= 1'b0;
      end else begin
        stage_vld[i] <= stage_vld_next[i];
      end
    end
  end

  assign out_valid = stage_vld[ROOT_W-1];
  assign root      = stage_root[ROOT_W-1];
  assign rem       = stage_rem[ROOT_W-1];
  assign out_side  = stage_side[ROOT_W-1];

endmodule

@@ design/npz_rdiv_pipe.sv @@
// Signed num / den (den > 0), rounded half away from zero, saturated to PZ_W bits.
// One quotient bit per stage after an overflow check.
module npz_rdiv_pipe
  import npz_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic signed [PZ_W-1:0]  quot,
  output logic [SIDE_W-1:0]       out_side
);

  localparam int A_W = NUM_W + 1;
  localparam int NB  = PZ_W;

  // magnitude
  logic              a_vld;
  logic              a_neg;
  logic [NUM_W-1:0]  a_mag;
  logic [DEN_W-1:0]  a_den;
  logic [SIDE_W-1:0] a_side;
  // rounding offset
  logic              b_vld;
  logic              b_neg;
  logic [A_W-1:0]    b_val;
  logic [DEN_W-1:0]  b_den;
  logic [SIDE_W-1:0] b_side;
  // overflow check
  logic              c_vld;
  logic              c_neg;
  logic              c_ovf;
  logic [A_W-1:0]    c_val;
  logic [DEN_W-1:0]  c_den;
  logic [SIDE_W-1:0] c_side;

  logic              bit_vld       [NB];
  logic              bit_vld_next  [NB];
  logic              bit_neg       [NB];
  logic              bit_neg_next  [NB];
  logic              bit_ovf       [NB];
  logic              bit_ovf_next  [NB];
  logic [A_W-1:0]    bit_rem       [NB];
  logic [A_W-1:0]    bit_rem_next  [NB];
  logic [NB-1:0]     bit_q         [NB];
  logic [NB-1:0]     bit_q_next    [NB];
  logic [DEN_W-1:0]  bit_den       [NB];
  logic [DEN_W-1:0]  bit_den_next  [NB];
  logic [SIDE_W-1:0] bit_side      [NB];
  logic [SIDE_W-1:0] bit_side_next [NB];

  logic [PZ_W-1:0]   sat_next;

  always_ff @(posedge clk) begin
    a_neg  <= num[NUM_W-1];
    a_mag  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    a_den  <= den;
    a_side <= in_side;
    b_neg  <= a_neg;
    b_val  <= {1'b0, a_mag} + A_W'(a_den >> 1);
    b_den  <= a_den;
    b_side <= a_side;
    c_neg  <= b_neg;
    c_ovf  <= (b_val >= A_W'({b_den, {NB{1'b0}}}));
    c_val  <= b_val;
    c_den  <= b_den;
    c_side <= b_side;
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      a_vld <= in_valid;
      b_vld <= a_vld;
      c_vld <= b_vld;
    end
  end

  always_comb begin
    logic              v_in;
    logic              n_in;
    logic              o_in;
    logic [A_W-1:0]    r_in;
    logic [NB-1:0]     q_in;
    logic [DEN_W-1:0]  d_in;
    logic [SIDE_W-1:0] s_in;
    logic [A_W-1:0]    dsh;
    logic              fits;
    for (int i = 0; i < NB; i++) begin
      if (i == 0) begin
        v_in = c_vld;
        n_in = c_neg;
        o_in = c_ovf;
        r_in = c_val;
        q_in = '0;
        d_in = c_den;
        s_in = c_side;
      end else begin
        v_in = bit_vld[i-1];
        n_in = bit_neg[i-1];
        o_in = bit_ovf[i-1];
        r_in = bit_rem[i-1];
        q_in = bit_q[i-1];
        d_in = bit_den[i-1];
        s_in = bit_side[i-1];
      end
      dsh  = A_W'(d_in) << (NB - 1 - i);
      fits = (r_in >= dsh);
      bit_vld_next[i]  = v_in;
      bit_neg_next[i]  = n_in;
      bit_ovf_next[i]  = o_in;
      bit_rem_next[i]  = fits ? (r_in - dsh) : r_in;
      bit_q_next[i]    = {q_in[NB-2:0], fits};
      bit_den_next[i]  = d_in;
      bit_side_next[i] = s_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NB; i++) begin
      bit_neg[i]  <= bit_neg_next[i];
      bit_ovf[i]  <= bit_ovf_next[i];
      bit_rem[i]  <= bit_rem_next[i];
      bit_q[i]    <= bit_q_next[i];
      bit_den[i]  <= bit_den_next[i];
      bit_side[i] <= bit_side_next[i];
      if (rst) begin
        bit_vld[i] <= 1'b0;
      end else begin
        bit_vld[i] <= bit_vld_next[i];
      end
    end
  end

  always_comb begin
    if (bit_neg[NB-1]) begin
      if (bit_ovf[NB-1] || bit_q[NB-1] > SAT_NEG) begin
        sat_next = SAT_NEG;
      end else begin
        sat_next = ~bit_q[NB-1] + 1'b1;
      end
    end else begin
      if (bit_ovf[NB-1] || bit_q[NB-1] > SAT_POS) begin
        sat_next = SAT_POS;
      end else begin
        sat_next = bit_q[NB-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    quot     <= $signed(sat_next);
    out_side <= bit_side[NB-1];
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= bit_vld[NB-1];
    end
  end

endmodule

@@ test/neutrino_pz_from_w_mass_top_test.sv @@
module neutrino_pz_from_w_mass_top_test;
  import npz_pkg::*;

  typedef struct packed {
    logic signed [F_W-1:0] lep_px;
    logic signed [F_W-1:0] lep_py;
    logic signed [F_W-1:0] lep_pz;
    logic [E_W-1:0]        lep_energy;
    logic signed [F_W-1:0] met_px;
    logic signed [F_W-1:0] met_py;
  } event_t;

  typedef struct packed {
    logic signed [PZ_W-1:0] pz_plus;
    logic signed [PZ_W-1:0] pz_minus;
    logic [XR_W-1:0]        en_plus;
    logic [XR_W-1:0]        en_minus;
    logic                   cplx;
    logic                   bad;
  } solution_t;

  typedef struct {
    event_t    ev;
    bit        typed;
    solution_t sol;
  } row_t;

  localparam int WATCHDOG = 4000;
  localparam int EV_W = $bits(event_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [F_W-1:0] lep_px = '0, lep_py = '0, lep_pz = '0, met_px = '0, met_py = '0;
  logic [E_W-1:0] lep_energy = '0;
  logic w_mass_wr = 1'b0;
  logic [W_W-1:0] w_mass_data = '0;
  logic done;
  logic signed [PZ_W-1:0] nu_pz_plus, nu_pz_minus;
  logic [XR_W-1:0] nu_energy_plus, nu_energy_minus;
  logic complex_roots, bad_input;

  neutrino_pz_from_w_mass_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .lep_px(lep_px), .lep_py(lep_py), .lep_pz(lep_pz), .lep_energy(lep_energy),
    .met_px(met_px), .met_py(met_py),
    .w_mass_wr(w_mass_wr), .w_mass_data(w_mass_data),
    .done(done), .nu_pz_plus(nu_pz_plus), .nu_pz_minus(nu_pz_minus),
    .nu_energy_plus(nu_energy_plus), .nu_energy_minus(nu_energy_minus),
    .complex_roots(complex_roots), .bad_input(bad_input)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [W_W-1:0] mass_shadow = W_MASS_RESET;
  solution_t pending_solutions[$];
  bit        pending_typed[$];
  solution_t pending_typed_sol[$];
  int mismatches = 0;
  int transfers_in = 0;
  int transfers_out = 0;
  int complex_seen = 0;
  int bad_seen = 0;
  int idle_cycles = 0;
  bit typed_now = 1'b0;
  solution_t typed_sol_now;

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint clamp_pz(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic logic [XR_W-1:0] nu_energy(longint pz, longint s);
    longint x, r, t;
    x = s + pz * pz;
    r = 0;
    for (int i = 22; i >= 0; i--) begin
      t = r | (longint'(1) << i);
      if (t * t <= x) r = t;
    end
    if (x - r * r > r) r++;
    return r > 1048575 ? EN_MAX : r[XR_W-1:0];
  endfunction

  function automatic solution_t solve_pz(event_t ev, logic [W_W-1:0] wm);
    solution_t sol;
    longint lx, ly, lz, e, mx, my, m, d, den, base, s, p1, p2, tr;
    logic [127:0] am, sq, dd, qv, r, t;
    bit cplx;
    lx = longint'(ev.lep_px); ly = longint'(ev.lep_py); lz = longint'(ev.lep_pz);
    e = longint'(ev.lep_energy);
    mx = longint'(ev.met_px); my = longint'(ev.met_py);
    m = longint'(wm) * longint'(wm) + 2 * (mx * lx + my * ly);
    d = e * e - lz * lz;
    sol = '0;
    if (d == 0) begin
      sol.bad = 1'b1;
      return sol;
    end
    den = 2 * (d < 0 ? -d : d);
    base = d < 0 ? -(m * lz) : m * lz;
    s = mx * mx + my * my;
    am = 128'(m < 0 ? -m : m);
    sq = am * am;
    dd = 128'(den) * 128'(2) * 128'(s);
    cplx = 1'b0;
    qv = '0;
    if (d < 0) qv = sq + dd;
    else if (sq < dd) cplx = 1'b1;
    else qv = sq - dd;
    if (cplx) begin
      p1 = clamp_pz(round_div(base, den));
      p2 = p1;
    end else begin
      r = '0;
      for (int i = 44; i >= 0; i--) begin
        t = r | (128'(1) << i);
        if (t * t <= qv) r = t;
      end
      tr = e * longint'(r[63:0]);
      p1 = clamp_pz(round_div(base + tr, den));
      p2 = clamp_pz(round_div(base - tr, den));
    end
    sol.pz_plus = p1[PZ_W-1:0];
    sol.pz_minus = p2[PZ_W-1:0];
    sol.en_plus = nu_energy(p1, s);
    sol.en_minus = nu_energy(p2, s);
    sol.cplx = cplx;
    return sol;
  endfunction

  // transfer in: record the prediction with the field values seen at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        event_t ev;
        ev = '{lep_px, lep_py, lep_pz, lep_energy, met_px, met_py};
        pending_solutions.push_back(solve_pz(ev, mass_shadow));
        pending_typed.push_back(typed_now);
        pending_typed_sol.push_back(typed_sol_now);
        transfers_in++;
      end
      if (w_mass_wr) mass_shadow <= w_mass_data;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      solution_t got, want, typed_want;
      bit typed;
      got = '{nu_pz_plus, nu_pz_minus, nu_energy_plus, nu_energy_minus,
              complex_roots, bad_input};
      transfers_out++;
      if (pending_solutions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        want = pending_solutions.pop_front();
        typed = pending_typed.pop_front();
        typed_want = pending_typed_sol.pop_front();
        if (typed && typed_want != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("typed row disagrees with predictor: %p vs %p", typed_want, want);
        end
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: expected %p, got %p", transfers_out, want, got);
        end
        if (want.cplx) complex_seen++;
        if (want.bad) bad_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer in %0d cycles", WATCHDOG);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  task automatic send_event(input event_t ev, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {lep_px, lep_py, lep_pz, lep_energy, met_px, met_py} <= ev;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (DIV_LAT + 110) @(posedge clk);
  endtask

  task automatic set_mass(input logic [W_W-1:0] v);
    drain();
    w_mass_wr <= 1'b1;
    w_mass_data <= v;
    @(posedge clk);
    w_mass_wr <= 1'b0;
    @(posedge clk);
  endtask

  function automatic event_t random_event();
    event_t ev;
    int sel;
    real p;
    longint ee;
    ev = EV_W'({$urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(99);
    if (sel < 65) begin
      // collider-like: lepton near massless, momenta up to ~1 TeV
      ev.lep_px = F_W'($urandom_range(32000) - 16000);
      ev.lep_py = F_W'($urandom_range(32000) - 16000);
      ev.lep_pz = F_W'($urandom_range(64000) - 32000);
      ev.met_px = F_W'($urandom_range(32000) - 16000);
      ev.met_py = F_W'($urandom_range(32000) - 16000);
      p = $sqrt(real'(ev.lep_px) ** 2 + real'(ev.lep_py) ** 2 + real'(ev.lep_pz) ** 2);
      ee = longint'(p) + $urandom_range(3) - 1;
      if (ee < 0) ee = 0;
      ev.lep_energy = ee > 524287 ? 19'h7FFFF : ee[E_W-1:0];
    end else if (sel < 72) begin
      // E equal to |pz|
      ev.lep_energy = ev.lep_pz < 0 ? E_W'(-ev.lep_pz) : E_W'(ev.lep_pz);
      if (ev.lep_pz == -524288) ev.lep_pz = 0;
    end else if (sel < 82) begin
      ev.lep_px = F_W'($urandom_range(64) - 32);
      ev.lep_py = F_W'($urandom_range(64) - 32);
      ev.lep_pz = F_W'($urandom_range(64) - 32);
      ev.lep_energy = E_W'($urandom_range(48));
      ev.met_px = F_W'($urandom_range(64) - 32);
      ev.met_py = F_W'($urandom_range(64) - 32);
    end
    return ev;
  endfunction

  row_t rows[$];
  int phase_idle[4] = '{0, 59, 0, 30};
  logic [W_W-1:0] phase_mass[4];

  initial begin
    solution_t bad_sol;
    bad_sol = '0;
    bad_sol.bad = 1'b1;
    rows.push_back('{'{20'sd0, 20'sd0, 20'sd0, 19'd0, 20'sd0, 20'sd0}, 1'b1, bad_sol});
    rows.push_back('{'{20'sd100, 20'sd0, -20'sd500, 19'd500, 20'sd40, 20'sd9}, 1'b1, bad_sol});
    rows.push_back('{'{20'sd3, -20'sd7, 20'sd524287, 19'd524287, -20'sd524288, 20'sd524287},
                     1'b1, bad_sol});
    rows.push_back('{'{20'sd500, 20'sd0, 20'sd0, 19'd500, 20'sd500, 20'sd0}, 1'b0, '0});
    rows.push_back('{'{20'sd500, 20'sd0, 20'sd0, 19'd500, -20'sd8000, 20'sd0}, 1'b0, '0});
    rows.push_back('{'{20'sd0, 20'sd400, 20'sd1000, 19'd200, 20'sd30, 20'sd60}, 1'b0, '0});
    rows.push_back('{'{-20'sd524288, -20'sd524288, -20'sd524288, 19'd524287,
                       -20'sd524288, -20'sd524288}, 1'b0, '0});
    rows.push_back('{'{20'sd524287, 20'sd524287, 20'sd524287, 19'd524287,
                       20'sd524287, 20'sd524287}, 1'b0, '0});
    rows.push_back('{'{20'sd524287, -20'sd524288, 20'sd1, 19'd524287,
                       -20'sd524288, 20'sd524287}, 1'b0, '0});
    rows.push_back('{'{20'sd1, 20'sd0, 20'sd0, 19'd1, 20'sd0, 20'sd0}, 1'b0, '0});
    rows.push_back('{'{20'sd2000, 20'sd1500, -20'sd3000, 19'd3905, 20'sd1200, -20'sd700},
                     1'b0, '0});
    rows.push_back('{'{20'sd0, 20'sd0, 20'sd1, 19'd2, 20'sd524287, 20'sd0}, 1'b0, '0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      typed_now <= rows[i].typed;
      typed_sol_now <= rows[i].sol;
      send_event(rows[i].ev, 0);
    end
    typed_now <= 1'b0;

    phase_mass = '{12'd0, 12'd4095, 12'($urandom_range(4095)), W_MASS_RESET};
    for (int ph = 0; ph < 4; ph++) begin
      set_mass(phase_mass[ph]);
      for (int n = 0; n < 500; n++) begin
        send_event(random_event(), phase_idle[ph]);
        if (ph == 1 && n == 250) drain();
      end
    end

    drain();
    $display("%0d transfers in, %0d out over four w_mass settings and four idling phases",
             transfers_in, transfers_out);
    $display("%0d complex-root and %0d bad-input results, %0d mismatches",
             complex_seen, bad_seen, mismatches);
    if (mismatches == 0 && pending_solutions.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
